/* rtl/ccr_pkg.sv */
// Shared types and constants for the closed Catmull-Rom loop evaluator.
// No dependencies.
`default_nettype none
package ccr_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_POS     = 2'd2,
        MODE_TANGENT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_SAT      = 2'd2,
        ST_TOO_FEW  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [15:0]        loop_param;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic [1:0]         status;
    } out_item_t;

    localparam int COORD_W = 32;
    // fraction bits of the loop parameter, matches the loop_param field
    localparam int PARAM_BITS = 16;
    // working width for the cubic: coefficients up to 24x, plus products
    localparam int ACC_W = 40;

endpackage
`default_nettype wire

/* rtl/closed_catmull_rom_evaluator.sv */
// Closed uniform Catmull-Rom loop evaluator with a control point table.
// Accepts one item on in_*, returns one result on out_*. Items: clear,
// append a point, evaluate position, evaluate tangent.
// Steps from acceptance to the result: clear, append and the too-few-points
// default return their result straight from idle; evaluation runs a scale
// and an index step, then per axis four table reads plus a load,
// coefficients, two (tangent) or three (position) multiplier passes and a
// halving, then an output step; a position on a single point skips the
// multiplier passes.
// One item is worked at a time; the back part takes the next item only
// after the previous result has been accepted.
// A two-entry queue lets new items be taken while the back part is busy.
// Reset empties the table (point count to zero) and drops queued items.
// When the receiver stalls, the result holds in the output register and
// the back part waits; the front keeps taking items until the queue fills.
// Depends on ccr_pkg, ccr_front, ccr_queue, ccr_back.
`default_nettype none
module closed_catmull_rom_evaluator #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ccr_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ccr_pkg::out_item_t      out_data
);
    import ccr_pkg::*;

    localparam int QW = $bits(in_item_t);

    logic      q_full, q_push, q_pop, q_ne;
    in_item_t  q_in, q_out;

    ccr_front u_front (
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    ccr_queue #(.W(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_ne),
        .pop_data  (q_out)
    );

    ccr_back #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_ne),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule
`default_nettype wire

/* rtl/ccr_queue.sv */
// Two-entry queue between the front and back parts.
// No dependencies.
`default_nettype none
module ccr_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      pop_data
);
    logic [W-1:0] mem_reg [2];
    logic         wr_reg, rd_reg;
    logic [1:0]   cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_reg];

    // store entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* rtl/ccr_front.sv */
// Front part: accept items and hand them to the queue.
// Depends on ccr_pkg.
`default_nettype none
module ccr_front (
    input  wire logic             in_valid,
    input  wire ccr_pkg::in_item_t in_data,
    output logic                  in_stall,
    input  wire logic             q_full,
    output logic                  q_push,
    output ccr_pkg::in_item_t     q_data
);
    import ccr_pkg::*;
    // stall while the queue is full; pass item as is
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_data   = in_data;
endmodule
`default_nettype wire

/* rtl/ccr_back.sv */
// Back part: point table, segment lookup and the Horner evaluation.
// Depends on ccr_pkg.
`default_nettype none
module ccr_back #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire ccr_pkg::in_item_t  q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ccr_pkg::out_item_t      out_data
);
    import ccr_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SC_W  = PARAM_BITS + CNT_W;
    localparam int MUL_W = ACC_W + PARAM_BITS + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_IDX, S_RD, S_LOAD, S_COEF, S_H1, S_H2, S_H3, S_FIN, S_OUT
    } state_t;

    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [COORD_W-1:0] mem_z [MAX_POINTS];

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         mode_reg;
    logic [PARAM_BITS-1:0] u_reg;
    logic [SC_W-1:0]    scaled_reg;
    logic [IDX_W-1:0]   idx_reg [4];
    logic [1:0]         rd_k_reg;   // which neighbor is being read
    logic [1:0]         ld_k_reg;
    logic               rd_live_reg;
    logic [1:0]         axis_reg;
    logic signed [COORD_W-1:0] rd_data_reg;
    logic signed [COORD_W-1:0] p_reg [4];
    logic signed [ACC_W-1:0]   a_reg, b_reg, t_reg, p1x2_reg;
    logic signed [ACC_W-1:0]   res_reg [3];
    logic               sat_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && !out_valid_reg;

    logic is_tan;
    assign is_tan = (mode_reg == MODE_TANGENT);

    // segment and local s
    logic [IDX_W-1:0] seg;
    logic [PARAM_BITS-1:0] s_val;
    logic [CNT_W-1:0] seg_full;
    assign seg_full = CNT_W'(scaled_reg >> PARAM_BITS);
    assign s_val    = scaled_reg[PARAM_BITS-1:0];
    assign seg      = (seg_full >= count_reg) ? IDX_W'(count_reg - 1'b1) : IDX_W'(seg_full);

    // wrap add: (seg + d) mod n, d < n
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] d,
                                                  input logic [CNT_W-1:0] n);
        logic [CNT_W:0] sum;
        begin
            sum = {1'b0, CNT_W'(a)} + {1'b0, d};
            if (sum >= {1'b0, n}) sum = sum - {1'b0, n};
            return IDX_W'(sum);
        end
    endfunction

    // shared multiplier: t * s, then round half up
    logic signed [ACC_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]  mul_r;
    always_comb
    begin
        mul_a = t_reg;
        mul_p = MUL_W'(mul_a) * MUL_W'($signed({1'b0, s_val}));
        mul_r = ACC_W'((mul_p + (MUL_W'(1) <<< (PARAM_BITS - 1))) >>> PARAM_BITS);
    end

    // final halving and clamp
    logic signed [ACC_W-1:0] half;
    assign half = (t_reg + ACC_W'(1)) >>> 1;

    function automatic logic signed [COORD_W-1:0] clamp(input logic signed [ACC_W-1:0] v);
        begin
            if (v > ACC_W'(32'sh7fffffff))
                return 32'sh7fffffff;
            else if (v < -ACC_W'(33'sh080000000))
                return 32'sh80000000;
            else
                return COORD_W'(v);
        end
    endfunction

    logic ovf;
    assign ovf = (half > ACC_W'(32'sh7fffffff)) || (half < -ACC_W'(33'sh080000000));

    logic signed [ACC_W-1:0] e0, e1, e2, e3;
    assign e0 = ACC_W'(p_reg[0]);
    assign e1 = ACC_W'(p_reg[1]);
    assign e2 = ACC_W'(p_reg[2]);
    assign e3 = ACC_W'(p_reg[3]);

    // table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.mode == MODE_APPEND && count_reg < CNT_W'(MAX_POINTS))
        begin
            mem_x[count_reg[IDX_W-1:0]] <= q_data.point_x;
            mem_y[count_reg[IDX_W-1:0]] <= q_data.point_y;
            mem_z[count_reg[IDX_W-1:0]] <= q_data.point_z;
        end
        case (axis_reg)
            2'd0:    rd_data_reg <= mem_x[idx_reg[rd_k_reg]];
            2'd1:    rd_data_reg <= mem_y[idx_reg[rd_k_reg]];
            default: rd_data_reg <= mem_z[idx_reg[rd_k_reg]];
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        mode_reg <= q_data.mode;
                        u_reg    <= q_data.loop_param[PARAM_BITS-1:0];
                        case (q_data.mode)
                            MODE_CLEAR:
                            begin
                                count_reg     <= '0;
                                out_reg       <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            MODE_APPEND:
                            begin
                                if (count_reg >= CNT_W'(MAX_POINTS))
                                    out_reg <= '{result_x: 32'sd0, result_y: 32'sd0,
                                                 result_z: 32'sd0, status: ST_FULL};
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    out_reg   <= '0;
                                end
                                out_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                                if (count_reg < CNT_W'(2) &&
                                    (q_data.mode == MODE_TANGENT || count_reg == '0))
                                begin
                                    out_reg <= '{result_x: 32'sd0, result_y: 32'sd0,
                                                 result_z: (q_data.mode == MODE_TANGENT) ?
                                                           (32'sd1 <<< FRAC_BITS) : 32'sd0,
                                                 status: ST_TOO_FEW};
                                    out_valid_reg  <= 1'b1;
                                end
                                else
                                    state_reg <= S_SCALE;
                            end
                        endcase
                    end
                end
                S_SCALE:
                begin
                    scaled_reg <= SC_W'(u_reg) * SC_W'(count_reg);
                    state_reg  <= S_IDX;
                end
                S_IDX:
                begin
                    idx_reg[0] <= wrap_add(seg, count_reg - 1'b1, count_reg);
                    idx_reg[1] <= seg;
                    idx_reg[2] <= wrap_add(seg, CNT_W'(1), count_reg);
                    idx_reg[3] <= wrap_add(seg, CNT_W'(2) >= count_reg ?
                                           CNT_W'(0) : CNT_W'(2), count_reg);
                    axis_reg   <= 2'd0;
                    rd_k_reg   <= 2'd0;
                    sat_reg    <= 1'b0;
                    state_reg  <= S_RD;
                end
                S_RD:
                begin
                    // stream four reads, one a cycle, each landing in the next cycle
                    rd_live_reg <= 1'b1;
                    ld_k_reg    <= rd_k_reg;
                    if (rd_live_reg)
                        p_reg[ld_k_reg] <= rd_data_reg;
                    rd_k_reg <= rd_k_reg + 1'b1;
                    if (rd_k_reg == 2'd3)
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    p_reg[ld_k_reg] <= rd_data_reg;
                    rd_live_reg     <= 1'b0;
                    state_reg       <= S_COEF;
                end
                S_COEF:
                begin
                    // single point: hand the point through
                    if (count_reg == CNT_W'(1))
                    begin
                        t_reg     <= e1 <<< 1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        a_reg    <= e2 - e0;
                        b_reg    <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
                        p1x2_reg <= e1 <<< 1;
                        if (is_tan)
                            t_reg <= 3 * (-e0 + 3 * e1 - 3 * e2 + e3);
                        else
                            t_reg <= -e0 + 3 * e1 - 3 * e2 + e3;
                        state_reg <= S_H1;
                    end
                end
                S_H1:
                begin
                    t_reg     <= mul_r + (is_tan ? (b_reg <<< 1) : b_reg);
                    state_reg <= S_H2;
                end
                S_H2:
                begin
                    t_reg     <= mul_r + a_reg;
                    state_reg <= is_tan ? S_FIN : S_H3;
                end
                S_H3:
                begin
                    t_reg     <= mul_r + p1x2_reg;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    res_reg[axis_reg] <= half;
                    if (ovf) sat_reg <= 1'b1;
                    if (axis_reg == 2'd2)
                        state_reg <= S_OUT;
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        rd_k_reg  <= 2'd0;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    out_reg <= '{result_x: clamp(res_reg[0]),
                                 result_y: clamp(res_reg[1]),
                                 result_z: clamp(res_reg[2]),
                                 status:   sat_reg ? ST_SAT : ST_OK};
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/ccr_checker.sv */
// Port-level checks for the Catmull-Rom loop evaluator, bound to the top.
// Depends on ccr_pkg.
`default_nettype none
module ccr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire ccr_pkg::out_item_t out_data
);
    import ccr_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // full append never returns coordinates
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FULL |->
        out_data.result_x == 0 && out_data.result_y == 0 && out_data.result_z == 0)
        else $error("dropped append carries data");

    // no result and no input stall straight out of reset
    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("result or stall after reset");

    // saturated status only with a clamped component
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_SAT |->
        out_data.result_x == 32'sh7fffffff || out_data.result_x == 32'sh80000000 ||
        out_data.result_y == 32'sh7fffffff || out_data.result_y == 32'sh80000000 ||
        out_data.result_z == 32'sh7fffffff || out_data.result_z == 32'sh80000000)
        else $error("saturation flag without clamp");
endmodule

bind closed_catmull_rom_evaluator ccr_checker u_ccr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
